/* hw/rtl/wpt_pkg.sv */
// Shared types and constants of the waypoint proportional tracker.
`timescale 1ns / 1ps

package wpt_pkg;

   // Input kind codes.
   localparam logic [1:0] KIND_POSE = 2'd0;
   localparam logic [1:0] KIND_LOAD = 2'd1;
   localparam logic [1:0] KIND_CMD  = 2'd2;

   // Command codes.
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_STOP   = 2'd1;
   localparam logic [1:0] CMD_PAUSE  = 2'd2;
   localparam logic [1:0] CMD_IGNORE = 2'd3;

   // Register port.
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 64;
   localparam logic [CSR_IW-1:0] CSR_GAIN_X        = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_GAIN_Y        = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_GAIN_YAW      = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_LIMITS_X      = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_LIMITS_Y      = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_LIMITS_YAW    = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_TOLERANCE_XY  = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_TOLERANCE_YAW = 3'd7;

   localparam logic [15:0] GAIN_RESET = 16'd256;

   // Depth of the queue between front and back.
   localparam int FQ_DEPTH = 4;
   localparam int FQ_AW    = $clog2(FQ_DEPTH);
   localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_RUNNING   = 2'd0,
      ST_STOPPED   = 2'd1,
      ST_PAUSED    = 2'd2,
      ST_COMPLETED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_POSE,
      OP_LOAD,
      OP_START,
      OP_STOP,
      OP_PAUSE
   } op_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] yaw;
   } pose_type;

   typedef struct packed {
      op_type   op;
      pose_type pose;
   } work_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic       reached;
   } step_type;

   typedef struct packed {
      logic [15:0] gain_x;
      logic [15:0] gain_y;
      logic [15:0] gain_yaw;
      logic [63:0] limits_x;
      logic [63:0] limits_y;
      logic [63:0] limits_yaw;
      logic [63:0] tolerance_xy;
      logic [31:0] tolerance_yaw;
   } cfg_type;

endpackage

/* hw/rtl/wpt_channels.sv */
// Request and response channel interfaces of the waypoint tracker.
`timescale 1ns / 1ps

interface wpt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading;
   logic [1:0]         command;

   modport source (output valid, kind, pos_x, pos_y, heading, command, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, heading, command, output ready);
endinterface

interface wpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] rate_yaw;
   logic [1:0]         status;
   logic               reached;

   modport source (output valid, vel_x, vel_y, rate_yaw, status, reached, input ready);
   modport sink   (input valid, vel_x, vel_y, rate_yaw, status, reached, output ready);
endinterface

/* hw/rtl/wpt_front.sv */
// Front end: decodes request words and buffers the useful ones in a short queue.
`timescale 1ns / 1ps

module wpt_front (
   input  logic              clock,
   input  logic              reset,
   wpt_req_if.sink           req,
   output logic              wk_valid,
   output wpt_pkg::work_type wk,
   input  logic              wk_pop
);
   import wpt_pkg::*;

   work_type           q_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]   cnt_ff, cnt_in;
   logic               keep;
   op_type             op;
   logic               push;

   // Ignored words (unknown kind, unknown command) never enter the queue.
   always_comb begin
      keep = 1'b0;
      op   = OP_POSE;
      unique case (req.kind)
         KIND_POSE: begin
            keep = 1'b1;
            op   = OP_POSE;
         end
         KIND_LOAD: begin
            keep = 1'b1;
            op   = OP_LOAD;
         end
         KIND_CMD: begin
            unique case (req.command)
               CMD_START: begin
                  keep = 1'b1;
                  op   = OP_START;
               end
               CMD_STOP: begin
                  keep = 1'b1;
                  op   = OP_STOP;
               end
               CMD_PAUSE: begin
                  keep = 1'b1;
                  op   = OP_PAUSE;
               end
               default: keep = 1'b0;
            endcase
         end
         default: keep = 1'b0;
      endcase
   end

   assign req.ready = (cnt_ff != FQ_CW'(FQ_DEPTH));
   assign push      = req.valid && req.ready && keep;
   assign wk_valid  = (cnt_ff != '0);
   assign wk        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = wk_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + FQ_CW'(push) - FQ_CW'(wk_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op, pose: '{x: req.pos_x, y: req.pos_y, yaw: req.heading}};
      end
   end

endmodule

/* hw/rtl/wpt_back.sv */
// Back end: waypoint memory, run status, target selection for each pose.
`timescale 1ns / 1ps

module wpt_back #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              wk_valid,
   input  wpt_pkg::work_type wk,
   output logic              wk_pop,
   input  logic [63:0]       tolerance_xy,
   input  logic [31:0]       tolerance_yaw,
   output wpt_pkg::step_type step,
   output wpt_pkg::pose_type tgt,
   output wpt_pkg::pose_type pose
);
   import wpt_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   pose_type          mem [QUEUE_DEPTH];
   pose_type          rd_ff;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   pose_type          target_ff, target_in;
   status_type        status_ff, status_in;
   step_type          step_ff, step_in;
   pose_type          tgt_ff;
   pose_type          pose_ff;

   logic [CW:0]       tail_sum;
   logic [AW-1:0]     tail;
   logic [AW-1:0]     head_inc;
   logic              full;
   logic              wr_en;
   logic              hit;
   logic              deq;

   // Absolute error within tolerance, done as two parallel signed compares.
   function automatic logic in_tol(input logic signed [31:0] t, input logic signed [31:0] p,
                                   input logic [31:0] tol);
      logic signed [33:0] e;
      logic signed [33:0] lim;
      e   = 34'(t) - 34'(p);
      lim = $signed({2'b00, tol});
      return (e <= lim) && (e >= -lim);
   endfunction

   assign wk_pop   = adv && wk_valid;
   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign head_inc = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign hit = in_tol(target_ff.x, wk.pose.x, tolerance_xy[31:0]) &&
                in_tol(target_ff.y, wk.pose.y, tolerance_xy[63:32]) &&
                in_tol(target_ff.yaw, wk.pose.yaw, tolerance_yaw);
   assign deq = hit && (count_ff != '0) && (status_ff == ST_RUNNING);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      target_in = target_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      step_in   = '{valid: 1'b0, status: status_ff, reached: 1'b0};
      if (wk_pop) begin
         unique case (wk.op)
            OP_LOAD: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_START: status_in = ST_RUNNING;
            OP_STOP: begin
               status_in = ST_STOPPED;
               count_in  = '0;
               head_in   = '0;
            end
            OP_PAUSE: status_in = ST_PAUSED;
            OP_POSE: begin
               if (deq) begin
                  target_in = rd_ff;
                  head_in   = head_inc;
                  count_in  = count_ff - 1'b1;
               end else if (hit) begin
                  status_in = ST_COMPLETED;
               end
               step_in = '{valid: 1'b1, status: status_in, reached: hit};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         target_ff <= '0;
         status_ff <= ST_RUNNING;
         step_ff   <= '{valid: 1'b0, status: ST_RUNNING, reached: 1'b0};
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         target_ff <= target_in;
         status_ff <= status_in;
         if (adv) begin
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tgt_ff  <= target_in;
         pose_ff <= wk.pose;
      end
   end

   // rd_ff always holds the entry at the head; a write to the new head forwards.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail] <= wk.pose;
      end
      if (wr_en && (tail == head_in)) begin
         rd_ff <= wk.pose;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   assign step = step_ff;
   assign tgt  = tgt_ff;
   assign pose = pose_ff;

endmodule

/* hw/rtl/wpt_drive.sv */
// Drive stages: per-axis gain multiply, scaling, clamping and response register.
`timescale 1ns / 1ps

module wpt_drive (
   input  logic              clock,
   input  logic              reset,
   output logic              adv,
   input  wpt_pkg::step_type step,
   input  wpt_pkg::pose_type tgt,
   input  wpt_pkg::pose_type pose,
   input  wpt_pkg::cfg_type  cfg,
   wpt_rsp_if.source         rsp
);
   import wpt_pkg::*;

   step_type           b_step_ff;
   logic signed [49:0] b_px_ff, b_py_ff, b_pyaw_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] vel_x_ff, vel_y_ff, rate_yaw_ff;
   status_type         status_ff;
   logic               reached_ff;

   function automatic logic signed [49:0] gain_mul(input logic signed [31:0] t,
                                                   input logic signed [31:0] p,
                                                   input logic [15:0] gain);
      logic signed [32:0] e;
      logic signed [16:0] g;
      logic signed [49:0] prod;
      e    = 33'(t) - 33'(p);
      g    = $signed({1'b0, gain});
      prod = e * g;
      return prod;
   endfunction

   // Floor shift to Q16.16, then min is applied first, then max.
   function automatic logic [31:0] scale_clamp(input logic signed [49:0] prod,
                                               input logic [63:0] lim);
      logic signed [41:0] q;
      logic signed [41:0] lo;
      logic signed [41:0] hi;
      q  = 42'(prod >>> 8);
      lo = $signed({{10{lim[31]}}, lim[31:0]});
      hi = $signed({{10{lim[63]}}, lim[63:32]});
      if (q < lo) begin
         q = lo;
      end else if (q > hi) begin
         q = hi;
      end
      return q[31:0];
   endfunction

   assign adv = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_step_ff    <= '{valid: 1'b0, status: ST_RUNNING, reached: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b_step_ff    <= step;
         rsp_valid_ff <= b_step_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_px_ff     <= gain_mul(tgt.x, pose.x, cfg.gain_x);
         b_py_ff     <= gain_mul(tgt.y, pose.y, cfg.gain_y);
         b_pyaw_ff   <= gain_mul(tgt.yaw, pose.yaw, cfg.gain_yaw);
         vel_x_ff    <= scale_clamp(b_px_ff, cfg.limits_x);
         vel_y_ff    <= scale_clamp(b_py_ff, cfg.limits_y);
         rate_yaw_ff <= scale_clamp(b_pyaw_ff, cfg.limits_yaw);
         status_ff   <= b_step_ff.status;
         reached_ff  <= b_step_ff.reached;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.vel_x    = vel_x_ff;
   assign rsp.vel_y    = vel_y_ff;
   assign rsp.rate_yaw = rate_yaw_ff;
   assign rsp.status   = status_ff;
   assign rsp.reached  = reached_ff;

endmodule

/* hw/rtl/waypoint_proportional_tracker.sv */
// Top level of the waypoint-following proportional tracker.
`timescale 1ns / 1ps

// The request channel carries three kinds of word: a measured pose, a waypoint
// to append to the waypoint queue, or a run command (start, stop, pause). Only
// pose words produce a response word on the response channel; it holds the
// clamped x and y velocity, the yaw rate, the run status after the step and a
// flag telling whether the previous target was reached.
// Configuration registers are written on the csr_ port. The user must write
// them only while no word is in flight; the block does not enforce this. A
// write takes effect on the next clock. Throughput is one request word per
// cycle while the front queue has room. A pose word passes the front queue,
// target selection against the waypoint memory, the three gain multipliers
// and the clamp into the response register, each step registered.
// When the receiver holds rsp ready low, the response register and the
// pipeline behind it freeze, the four-word front queue keeps accepting, and
// req ready drops only once that queue is full.
// Synchronous reset empties both queues, sets the target to zero, the status
// to running and the registers to their defaults (gains 1.0, limits and
// tolerances zero). The waypoint memory is not cleared; entries are always
// written before they are read.

module waypoint_proportional_tracker #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   wpt_req_if.sink                      req_chan,
   wpt_rsp_if.source                    rsp_chan,
   input  logic                         csr_we,
   input  logic [wpt_pkg::CSR_IW-1:0]   csr_index,
   input  logic [wpt_pkg::CSR_DW-1:0]   csr_wdata
);
   import wpt_pkg::*;

   cfg_type  cfg_ff;
   logic     wk_valid;
   work_type wk;
   logic     wk_pop;
   logic     adv;
   step_type step;
   pose_type tgt;
   pose_type pose;

   // Register file. Narrow registers keep the low bits of the written data.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain_x: GAIN_RESET, gain_y: GAIN_RESET, gain_yaw: GAIN_RESET,
                     default: '0};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_X:        cfg_ff.gain_x        <= csr_wdata[15:0];
            CSR_GAIN_Y:        cfg_ff.gain_y        <= csr_wdata[15:0];
            CSR_GAIN_YAW:      cfg_ff.gain_yaw      <= csr_wdata[15:0];
            CSR_LIMITS_X:      cfg_ff.limits_x      <= csr_wdata;
            CSR_LIMITS_Y:      cfg_ff.limits_y      <= csr_wdata;
            CSR_LIMITS_YAW:    cfg_ff.limits_yaw    <= csr_wdata;
            CSR_TOLERANCE_XY:  cfg_ff.tolerance_xy  <= csr_wdata;
            CSR_TOLERANCE_YAW: cfg_ff.tolerance_yaw <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Front: decode and buffer request words.
   wpt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .wk_valid (wk_valid),
      .wk       (wk),
      .wk_pop   (wk_pop)
   );

   // Back: queue, status and target update; one word per cycle unless stalled.
   wpt_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .wk_valid      (wk_valid),
      .wk            (wk),
      .wk_pop        (wk_pop),
      .tolerance_xy  (cfg_ff.tolerance_xy),
      .tolerance_yaw (cfg_ff.tolerance_yaw),
      .step          (step),
      .tgt           (tgt),
      .pose          (pose)
   );

   // Multiply and clamp; adv stalls the back end when the response is held.
   wpt_drive u_drive (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .step  (step),
      .tgt   (tgt),
      .pose  (pose),
      .cfg   (cfg_ff),
      .rsp   (rsp_chan)
   );

endmodule

/* hw/rtl/wpt_checker.sv */
// Port-level assertions for the waypoint tracker and their bind statement.
`timescale 1ns / 1ps

module wpt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_vel_x,
   input logic signed [31:0] rsp_vel_y,
   input logic signed [31:0] rsp_rate_yaw,
   input logic [1:0]         rsp_status,
   input logic               rsp_reached
);
   import wpt_pkg::*;

   logic [3:0] pend_ff, pend_in;
   logic       pose_in;
   logic       rsp_out;

   assign pose_in = req_valid && req_ready && (req_kind == KIND_POSE);
   assign rsp_out = rsp_valid && rsp_ready;
   assign pend_in = pend_ff + 4'(pose_in) - 4'(rsp_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vel_x) && $stable(rsp_vel_y)
         && $stable(rsp_rate_yaw) && $stable(rsp_status) && $stable(rsp_reached))
      else $error("stalled response changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("response without an outstanding pose");

   a_reach_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reached |-> rsp_status != ST_STOPPED && rsp_status != ST_PAUSED)
      else $error("reached target left status stopped or paused");

endmodule

bind waypoint_proportional_tracker wpt_checker u_wpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_kind     (req_chan.kind),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_vel_x    (rsp_chan.vel_x),
   .rsp_vel_y    (rsp_chan.vel_y),
   .rsp_rate_yaw (rsp_chan.rate_yaw),
   .rsp_status   (rsp_chan.status),
   .rsp_reached  (rsp_chan.reached)
);

/* verif/waypoint_proportional_tracker_tb.sv */
// Self-checking testbench for the waypoint proportional tracker.
`timescale 1ns / 1ps

// The bench drives request words into the tracker and checks every response
// word against a predictor of its own. The predictor keeps a private copy of
// the waypoint queue, the current target, the run status and the register
// settings, and works out the response of each pose word when that word is
// accepted.
//
// The run has two parts. A short directed table comes first: register
// defaults, field extremes, every command, ignored words and the status
// rules. Rows whose response is plain from the status rules carry it typed
// in; all other rows go through the predictor. Three random phases follow,
// each with its own register settings and idle pattern. The largest share
// of random words are poses placed near the current target, so that targets
// are reached and the waypoint queue is walked. The rest are waypoint loads,
// commands, poses anywhere in the field range and words the tracker ignores.
//
// One phase fills the waypoint queue past its depth so that the overflow
// drop is exercised. Another holds the response side off for a long
// stretch while words keep coming, and later pauses until every pending
// response has drained.

module waypoint_proportional_tracker_tb;

   import wpt_pkg::*;

   localparam int DEPTH        = 64;
   localparam int PHASE_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 12;    // front queue of four plus a three-stage pipe
   localparam int HOLD_CYCLES  = 150;
   localparam int STALL_LIMIT  = 3000;

   localparam logic [1:0]  KIND_NONE = 2'd3;   // a kind the tracker ignores
   localparam logic [31:0] MAX32     = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN32     = 32'h8000_0000;

   typedef struct packed {
      logic [1:0] kind;
      pose_type   pose;
      logic [1:0] command;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] rate_yaw;
      status_type         status;
      logic               reached;
   } motion_type;

   typedef struct packed {
      logic                is_csr;
      logic [CSR_IW-1:0]   csr_index;
      logic [CSR_DW-1:0]   csr_value;
      req_word_type        word;
      logic                typed;
      motion_type          result;
   } plan_row_type;

   logic clock;
   logic reset;
   logic               csr_we;
   logic [CSR_IW-1:0]  csr_index;
   logic [CSR_DW-1:0]  csr_wdata;

   wpt_req_if req_bus ();
   wpt_rsp_if rsp_bus ();

   waypoint_proportional_tracker #(
      .QUEUE_DEPTH (DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: its own waypoint queue, target, status and registers.
   pose_type    wp_store [DEPTH];
   int          wp_count = 0;
   int          wp_head  = 0;
   pose_type    aim      = '0;
   status_type  mode     = ST_RUNNING;
   logic [15:0] k_x      = GAIN_RESET;
   logic [15:0] k_y      = GAIN_RESET;
   logic [15:0] k_yaw    = GAIN_RESET;
   logic [63:0] lim_x    = '0;
   logic [63:0] lim_y    = '0;
   logic [63:0] lim_yaw  = '0;
   logic [63:0] tol_xy   = '0;
   logic [31:0] tol_yaw  = '0;

   // Responses predicted for accepted pose words, oldest first.
   motion_type   pending [$];
   plan_row_type plan [$];

   int mismatches   = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_req     = 1'b0;
   bit hold_off     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic bit in_band(longint err, logic [31:0] tol);
      longint mag;
      mag = (err < 0) ? -err : err;
      return mag <= longint'(tol);
   endfunction

   // Gain times error, Q24.24 floored back to Q16.16, then clamped. The
   // minimum is tested first, so with inverted limits it wins for values below it.
   function automatic logic [31:0] drive_command(longint err, logic [15:0] gain,
                                                 logic [63:0] lim);
      longint prod;
      longint lo;
      longint hi;
      prod = (err * longint'(gain)) >>> 8;
      lo   = longint'($signed(lim[31:0]));
      hi   = longint'($signed(lim[63:32]));
      if (prod < lo)
         prod = lo;
      else if (prod > hi)
         prod = hi;
      return prod[31:0];
   endfunction

   // Applies one accepted word to the predictor state. Returns 1 and fills
   // the response when the word is a pose.
   function automatic bit track_step(input req_word_type w, output motion_type m);
      longint ex;
      longint ey;
      longint eh;
      bit     hit;
      m = '0;
      case (w.kind)
         KIND_LOAD: begin
            // A full queue drops the new waypoint.
            if (wp_count < DEPTH) begin
               wp_store[(wp_head + wp_count) % DEPTH] = w.pose;
               wp_count++;
            end
            return 1'b0;
         end
         KIND_CMD: begin
            case (w.command)
               CMD_START: mode = ST_RUNNING;
               CMD_STOP: begin
                  mode     = ST_STOPPED;
                  wp_count = 0;
                  wp_head  = 0;
               end
               CMD_PAUSE: mode = ST_PAUSED;
               default: ;
            endcase
            return 1'b0;
         end
         KIND_POSE: ;
         default: return 1'b0;
      endcase

      ex  = longint'(aim.x) - longint'(w.pose.x);
      ey  = longint'(aim.y) - longint'(w.pose.y);
      eh  = longint'(aim.yaw) - longint'(w.pose.yaw);
      hit = in_band(ex, tol_xy[31:0]) && in_band(ey, tol_xy[63:32]) && in_band(eh, tol_yaw);
      if (hit) begin
         if (wp_count > 0 && mode == ST_RUNNING) begin
            aim     = wp_store[wp_head];
            wp_head = (wp_head + 1) % DEPTH;
            wp_count--;
         end else begin
            mode = ST_COMPLETED;
         end
      end

      // The command is formed against the target after any update.
      ex = longint'(aim.x) - longint'(w.pose.x);
      ey = longint'(aim.y) - longint'(w.pose.y);
      eh = longint'(aim.yaw) - longint'(w.pose.yaw);
      m.vel_x    = drive_command(ex, k_x, lim_x);
      m.vel_y    = drive_command(ey, k_y, lim_y);
      m.rate_yaw = drive_command(eh, k_yaw, lim_yaw);
      m.status   = mode;
      m.reached  = hit;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Table rows and word construction
   // ------------------------------------------------------------------

   function automatic req_word_type mk_word(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] h, logic [1:0] cmd);
      req_word_type w;
      w.kind     = kind;
      w.pose.x   = x;
      w.pose.y   = y;
      w.pose.yaw = h;
      w.command  = cmd;
      return w;
   endfunction

   function automatic plan_row_type word_row(req_word_type w);
      plan_row_type r;
      r      = '0;
      r.word = w;
      return r;
   endfunction

   // A row whose response has zero commands and is read off the status rules.
   function automatic plan_row_type still_row(req_word_type w, status_type s, logic hit);
      plan_row_type r;
      r                = '0;
      r.word           = w;
      r.typed          = 1'b1;
      r.result.status  = s;
      r.result.reached = hit;
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      plan_row_type r;
      r           = '0;
      r.is_csr    = 1'b1;
      r.csr_index = idx;
      r.csr_value = val;
      return r;
   endfunction

   // Appends one row to the end of the table.
   function automatic void add_row(plan_row_type r);
      plan = {plan, r};
   endfunction

   // A value near the center: mostly inside the tolerance, sometimes just out.
   function automatic logic [31:0] near_value(logic [31:0] center, logic [31:0] tol);
      longint span;
      longint off;
      span = (tol > 32'h3FFF_FFFF) ? 64'sh3FFF_FFFF : longint'(tol);
      if ($urandom_range(99) < 88) begin
         off = longint'($urandom_range(32'(2 * span))) - span;
      end else begin
         off = span + 1 + longint'($urandom_range(255));
         if ($urandom_range(1) == 1)
            off = -off;
      end
      return center + 32'(off);
   endfunction

   // Random word, shaped by the predictor's current target and tolerances.
   function automatic req_word_type next_word();
      req_word_type w;
      int           pick;
      w    = mk_word(KIND_POSE, $urandom, $urandom, $urandom, 2'($urandom));
      pick = $urandom_range(99);
      if (pick < 45) begin
         w.pose.x   = near_value(aim.x, tol_xy[31:0]);
         w.pose.y   = near_value(aim.y, tol_xy[63:32]);
         w.pose.yaw = near_value(aim.yaw, tol_yaw);
      end else if (pick < 57) begin
         // A pose anywhere in the field range.
      end else if (pick < 82) begin
         w.kind = KIND_LOAD;
         if ($urandom_range(9) < 7) begin
            w.pose.x   = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            w.pose.y   = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            w.pose.yaw = $urandom_range(32'h0006_0000) - 32'h0003_0000;
         end
      end else if (pick < 95) begin
         w.kind    = KIND_CMD;
         w.command = ($urandom_range(9) < 7) ? CMD_START : 2'($urandom_range(3));
      end else begin
         w.kind = KIND_NONE;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offers one word, with random idle cycles in front of it, and feeds the
   // predictor at the edge where the word is taken. Entered and left at a
   // falling edge; valid stays high so that back-to-back words need no gap.
   task automatic send_word(input req_word_type w, input bit typed, input motion_type known);
      motion_type m;
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.kind    = w.kind;
      req_bus.pos_x   = w.pose.x;
      req_bus.pos_y   = w.pose.y;
      req_bus.heading = w.pose.yaw;
      req_bus.command = w.command;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (track_step(w, m))
         pending = {pending, (typed ? known : m)};
      @(negedge clock);
   endtask

   // Stops offering words and waits until every predicted response has come,
   // then lets the pipeline run dry of loads and commands too.
   task automatic settle();
      req_bus.valid = 1'b0;
      while (pending.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_setting(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      settle();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_GAIN_X:        k_x     = val[15:0];
         CSR_GAIN_Y:        k_y     = val[15:0];
         CSR_GAIN_YAW:      k_yaw   = val[15:0];
         CSR_LIMITS_X:      lim_x   = val;
         CSR_LIMITS_Y:      lim_y   = val;
         CSR_LIMITS_YAW:    lim_yaw = val;
         CSR_TOLERANCE_XY:  tol_xy  = val;
         CSR_TOLERANCE_YAW: tol_yaw = val[31:0];
         default: ;
      endcase
   endtask

   // Register settings of the random phases. Together with the directed
   // table they reach zero and full-scale gains, full-range, narrow and
   // inverted limits, and zero and all-ones tolerances.
   task automatic set_profile(int phase);
      logic [31:0] m;
      m = $urandom_range(MAX32, 1);
      case (phase)
         0: begin
            write_setting(CSR_GAIN_X, 64'($urandom_range(16'hFFFF)));
            write_setting(CSR_GAIN_Y, 64'($urandom_range(16'hFFFF)));
            write_setting(CSR_GAIN_YAW, 64'($urandom_range(16'hFFFF)));
            write_setting(CSR_LIMITS_X, {MAX32, MIN32});
            write_setting(CSR_LIMITS_Y, {m, -m});
            write_setting(CSR_LIMITS_YAW, {32'h0003_0000, 32'hFFFD_0000});
            write_setting(CSR_TOLERANCE_XY, {32'h0002_0000, 32'h0001_0000});
            write_setting(CSR_TOLERANCE_YAW, 64'h0000_8000);
         end
         1: begin
            write_setting(CSR_GAIN_X, 64'h0000);
            write_setting(CSR_GAIN_Y, 64'hFFFF);
            write_setting(CSR_GAIN_YAW, 64'h0001);
            // Minimum above maximum: the minimum wins below it.
            write_setting(CSR_LIMITS_X, {32'hFFFF_0000, 32'h0001_0000});
            write_setting(CSR_LIMITS_Y, {MAX32, MIN32});
            write_setting(CSR_LIMITS_YAW, {$urandom, $urandom});
            write_setting(CSR_TOLERANCE_XY, 64'h0);
            write_setting(CSR_TOLERANCE_YAW, 64'hFFFF_FFFF);
         end
         default: begin
            write_setting(CSR_GAIN_X, 64'($urandom));
            write_setting(CSR_GAIN_Y, 64'($urandom));
            write_setting(CSR_GAIN_YAW, 64'($urandom));
            write_setting(CSR_LIMITS_X, {$urandom, $urandom});
            write_setting(CSR_LIMITS_Y, {$urandom, $urandom});
            write_setting(CSR_LIMITS_YAW, {$urandom, $urandom});
            write_setting(CSR_TOLERANCE_XY, {32'hFFFF_FFFF,
                                             32'($urandom_range(32'h000F_FFFF))});
            write_setting(CSR_TOLERANCE_YAW, 64'($urandom_range(32'h0003_FFFF)));
         end
      endcase
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int phase);
      req_word_type w;
      int           counted;
      bit           held;
      bit           drained;
      counted = 0;
      held    = 1'b0;
      drained = 1'b0;
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      set_profile(phase);
      if (phase == 1) begin
         // Empty the queue, then load past its depth so the overflow is dropped.
         send_word(mk_word(KIND_CMD, 0, 0, 0, CMD_STOP), 1'b0, '0);
         repeat (DEPTH + 6)
            send_word(mk_word(KIND_LOAD, $urandom, $urandom, $urandom, 2'($urandom)),
                      1'b0, '0);
         send_word(mk_word(KIND_CMD, 0, 0, 0, CMD_START), 1'b0, '0);
      end
      while (counted < PHASE_ITEMS) begin
         if (phase == 2 && counted == 20 && !held) begin
            // The response side stalls while words keep arriving.
            held     = 1'b1;
            hold_req = 1'b1;
         end
         if (phase == 2 && counted == 70 && !drained) begin
            drained = 1'b1;
            settle();
         end
         w = next_word();
         send_word(w, 1'b0, '0);
         if (!(w.kind == KIND_NONE || (w.kind == KIND_CMD && w.command == CMD_IGNORE)))
            counted++;
      end
   endtask

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic note_mismatch(string what, logic signed [31:0] got,
                                logic signed [31:0] want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Response side: random ready, or held low during a hold-off stretch.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = !hold_off && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // The hold-off runs in its own process so the sender keeps going meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end
      end
   end

   // Each response word taken is compared with the oldest prediction.
   initial begin
      motion_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending.size() == 0) begin
               note_mismatch("response word with none pending", 1, 0);
            end else begin
               want = pending.pop_front();
               if (rsp_bus.vel_x !== want.vel_x)
                  note_mismatch("vel_x", rsp_bus.vel_x, want.vel_x);
               if (rsp_bus.vel_y !== want.vel_y)
                  note_mismatch("vel_y", rsp_bus.vel_y, want.vel_y);
               if (rsp_bus.rate_yaw !== want.rate_yaw)
                  note_mismatch("rate_yaw", rsp_bus.rate_yaw, want.rate_yaw);
               if (rsp_bus.status !== want.status)
                  note_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
               if (rsp_bus.reached !== want.reached)
                  note_mismatch("reached", 32'(rsp_bus.reached), 32'(want.reached));
            end
         end
      end
   end

   // Ends the run when no word moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      plan_row_type row;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_POSE;
      req_bus.pos_x   = '0;
      req_bus.pos_y   = '0;
      req_bus.heading = '0;
      req_bus.command = CMD_START;

      // Default registers: unit gains, zero limits, so every command is zero.
      // Zero tolerance: only an exact pose reaches the target.
      add_row(still_row(mk_word(KIND_POSE, 0, 0, 0, CMD_START), ST_COMPLETED, 1'b1));
      add_row(still_row(mk_word(KIND_POSE, 1, 0, 0, CMD_STOP), ST_COMPLETED, 1'b0));
      add_row(word_row(mk_word(KIND_CMD, 0, 0, 0, CMD_START)));
      add_row(word_row(mk_word(KIND_LOAD, MAX32, MAX32, MAX32, CMD_IGNORE)));
      add_row(word_row(mk_word(KIND_LOAD, MIN32, MIN32, MIN32, CMD_PAUSE)));
      // Reaching the target while running takes the oldest waypoint.
      add_row(still_row(mk_word(KIND_POSE, 0, 0, 0, CMD_START), ST_RUNNING, 1'b1));
      add_row(still_row(mk_word(KIND_POSE, MAX32, MAX32, MAX32, CMD_START),
                        ST_RUNNING, 1'b1));
      // Reached with an empty queue: the run is completed.
      add_row(still_row(mk_word(KIND_POSE, MIN32, MIN32, MIN32, CMD_START),
                        ST_COMPLETED, 1'b1));
      // Pause, then a load and words that must change nothing.
      add_row(word_row(mk_word(KIND_CMD, 0, 0, 0, CMD_PAUSE)));
      add_row(word_row(mk_word(KIND_LOAD, 32'h1234_5678, 32'hEDCB_A988, 32'h0001_921F,
                               CMD_START)));
      add_row(word_row(mk_word(KIND_CMD, 0, 0, 0, CMD_IGNORE)));
      add_row(word_row(mk_word(KIND_NONE, '1, '1, '1, CMD_STOP)));
      add_row(still_row(mk_word(KIND_POSE, 0, 0, 0, CMD_START), ST_PAUSED, 1'b0));
      // Stop empties the queue, so a later reach completes the run.
      add_row(word_row(mk_word(KIND_CMD, 0, 0, 0, CMD_STOP)));
      add_row(word_row(mk_word(KIND_CMD, 0, 0, 0, CMD_START)));
      add_row(still_row(mk_word(KIND_POSE, MIN32, MIN32, MIN32, CMD_START),
                        ST_COMPLETED, 1'b1));

      // Wide limits and real gains; from here on the predictor decides.
      add_row(csr_row(CSR_GAIN_X, 64'hFFFF));
      add_row(csr_row(CSR_GAIN_Y, 64'h0100));
      add_row(csr_row(CSR_GAIN_YAW, 64'h0080));
      add_row(csr_row(CSR_LIMITS_X, {MAX32, MIN32}));
      add_row(csr_row(CSR_LIMITS_Y, {MAX32, MIN32}));
      add_row(csr_row(CSR_LIMITS_YAW, {32'h0001_0000, 32'hFFFF_0000}));
      add_row(csr_row(CSR_TOLERANCE_XY, {32'h0000_8000, 32'h0000_8000}));
      add_row(csr_row(CSR_TOLERANCE_YAW, 64'h0001_0000));
      add_row(word_row(mk_word(KIND_LOAD, 0, 0, 0, CMD_START)));
      add_row(word_row(mk_word(KIND_LOAD, 32'h0001_8000, 32'hFFFD_8000, 32'h0000_C000,
                               CMD_START)));
      // Largest negative error, saturated on every axis, then a pose near the target.
      add_row(word_row(mk_word(KIND_POSE, MAX32, MAX32, MAX32, CMD_START)));
      add_row(word_row(mk_word(KIND_POSE, 32'h8000_4000, 32'h8000_4000, 32'h8000_8000,
                               CMD_START)));
      // Odd errors exercise the floor of negative products.
      add_row(word_row(mk_word(KIND_POSE, 1, 32'hFFFF_FFFF, 3, CMD_START)));
      add_row(word_row(mk_word(KIND_POSE, MAX32, MIN32, 0, CMD_START)));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 38;
      rsp_idle_pct = 47;
      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr)
            write_setting(row.csr_index, row.csr_value);
         else
            send_word(row.word, row.typed, row.result);
      end

      run_phase(38, 47, 0);
      run_phase(47, 38, 1);
      run_phase(0, 0, 2);

      settle();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
